// ===== rtl/dcmf_pkg.sv =====
// Shared types and constants for the dark channel minimum filter.
package dcmf_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT     = 4096;
   localparam int SLOT_W         = 4;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_type;

   typedef struct packed {
      logic [7:0]  dark_value;
      logic [11:0] out_col;
      logic [11:0] out_row;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [12:0] width;
      logic [12:0] height;
      logic [2:0]  radius;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        pix;
      logic              we;
      logic [11:0]       col;
      logic [11:0]       row;
      logic [SLOT_W-1:0] slot;
      logic [11:0]       rlo;
      logic [11:0]       rhi;
      logic [11:0]       clo;
      logic [11:0]       chi;
      logic              has_out;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_OUT
   } back_state_type;

endpackage

// ===== rtl/dcmf_front.sv =====
// Front end: pixel intake, raster tracking and result-range classification.
module dcmf_front #(
   parameter int MAX_RADIUS = dcmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dcmf_pkg::req_type pix_in,
   input  logic              accept,
   input  dcmf_pkg::cfg_type cfg,
   output dcmf_pkg::job_type job
);

   localparam int SLOTS = 2 * MAX_RADIUS + 1;

   logic [11:0]                 in_col_ff, in_col_in;
   logic [11:0]                 in_row_ff, in_row_in;
   logic [dcmf_pkg::SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [12:0]                 emit_col_ff, emit_col_in;

   logic signed [14:0] x, y, w, h, rad, rlo, rhi, clo, chi, chi_raw;
   logic               row_end, last_row, has_rows, has_cols;
   logic [7:0]         m0, m1;

   always_comb begin
      m0 = (pix_in.green < pix_in.blue) ? pix_in.green : pix_in.blue;
      m1 = (pix_in.red < m0) ? pix_in.red : m0;
      x   = signed'({3'b000, in_col_ff});
      y   = signed'({3'b000, in_row_ff});
      w   = signed'({2'b00, cfg.width});
      h   = signed'({2'b00, cfg.height});
      rad = signed'({12'd0, cfg.radius});
      row_end  = (x + 15'sd1 >= w);
      last_row = (y + 15'sd1 >= h);
      if (last_row) begin
         rlo = (y >= rad) ? y - rad : 15'sd0;
         rhi = (y < h - 15'sd1) ? y : h - 15'sd1;
         has_rows = (rlo <= rhi);
      end else begin
         rlo = y - rad;
         rhi = y - rad;
         has_rows = (y >= rad);
      end
      clo     = signed'({2'b00, emit_col_ff});
      chi_raw = row_end ? w - 15'sd1 : x - rad;
      chi     = (chi_raw - clo > 15'(MAX_RADIUS)) ? clo + 15'(MAX_RADIUS) : chi_raw;
      has_cols = (chi >= clo);

      job.pix     = m1;
      job.we      = ({3'b000, in_col_ff} < 15'(MAX_WIDTH));
      job.col     = in_col_ff;
      job.row     = in_row_ff;
      job.slot    = in_slot_ff;
      job.rlo     = rlo[11:0];
      job.rhi     = rhi[11:0];
      job.clo     = clo[11:0];
      job.chi     = chi[11:0];
      job.has_out = has_rows && has_cols;

      emit_col_in = has_cols ? chi[12:0] + 13'd1 : emit_col_ff;
      in_col_in   = in_col_ff + 12'd1;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      if (row_end) begin
         in_col_in   = 12'd0;
         emit_col_in = 13'd0;
         if (last_row) begin
            in_row_in  = 12'd0;
            in_slot_in = '0;
         end else begin
            in_row_in  = in_row_ff + 12'd1;
            in_slot_in = (in_slot_ff == dcmf_pkg::SLOT_W'(SLOTS - 1)) ? '0
                       : in_slot_ff + dcmf_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         emit_col_ff <= '0;
      end else if (accept) begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         emit_col_ff <= emit_col_in;
      end
   end

endmodule

// ===== rtl/dcmf_queue.sv =====
// Two-entry job queue between front and back end.
module dcmf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dcmf_pkg::job_type push_data,
   input  logic              pop,
   output dcmf_pkg::job_type head,
   output logic              full,
   output logic              empty
);

   dcmf_pkg::job_type entry_ff [2];
   logic              wptr_ff, rptr_ff;
   logic [1:0]        count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/dcmf_back.sv =====
// Back end: line store, window minimum scan and result output.
module dcmf_back #(
   parameter int MAX_RADIUS = dcmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dcmf_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   input  dcmf_pkg::cfg_type cfg,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcmf_pkg::rsp_type rsp_data
);

   localparam int SLOTS  = 2 * MAX_RADIUS + 1;
   localparam int DEPTH  = SLOTS * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SW     = dcmf_pkg::SLOT_W;

   dcmf_pkg::back_state_type state_ff, state_in;
   dcmf_pkg::job_type        job_ff;

   logic [7:0]  mem [DEPTH];
   logic [7:0]  rdata_ff, min_ff;
   logic        pend_ff;
   logic [11:0] r_ff, c_ff, sr_ff, sc_ff, whi_ff, wclo_ff, wchi_ff;

   logic [11:0]   rad12, wlo, whi, wclo, wchi;
   logic [12:0]   rsum, csum, hm1, wm1;
   logic [11:0]   row_gap;
   logic [SW:0]   rslot;
   logic [ADDR_W-1:0] raddr, waddr;
   logic          scan_done, last_res;

   always_comb begin
      rad12 = {9'd0, cfg.radius};
      hm1   = cfg.height - 13'd1;
      wm1   = cfg.width - 13'd1;
      rsum  = {1'b0, r_ff} + {1'b0, rad12};
      csum  = {1'b0, c_ff} + {1'b0, rad12};
      wlo   = (r_ff > rad12) ? r_ff - rad12 : 12'd0;
      wclo  = (c_ff > rad12) ? c_ff - rad12 : 12'd0;
      whi   = (rsum < hm1) ? rsum[11:0] : hm1[11:0];
      wchi  = (csum < wm1) ? csum[11:0] : wm1[11:0];
      row_gap = job_ff.row - sr_ff;
      rslot = ({1'b0, job_ff.slot} >= {1'b0, row_gap[SW-1:0]})
            ? {1'b0, job_ff.slot} - {1'b0, row_gap[SW-1:0]}
            : {1'b0, job_ff.slot} + (SW+1)'(SLOTS) - {1'b0, row_gap[SW-1:0]};
      raddr = ADDR_W'(rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sc_ff);
      waddr = ADDR_W'(job_ff.slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(job_ff.col);
      scan_done = (sr_ff == whi_ff) && (sc_ff == wchi_ff);
      last_res  = (r_ff == job_ff.rhi) && (c_ff == job_ff.chi);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcmf_pkg::ST_IDLE:  if (!empty) state_in = dcmf_pkg::ST_WRITE;
         dcmf_pkg::ST_WRITE: state_in = job_ff.has_out ? dcmf_pkg::ST_SETUP
                                                       : dcmf_pkg::ST_IDLE;
         dcmf_pkg::ST_SETUP: state_in = dcmf_pkg::ST_SCAN;
         dcmf_pkg::ST_SCAN:  if (scan_done) state_in = dcmf_pkg::ST_DRAIN;
         dcmf_pkg::ST_DRAIN: state_in = dcmf_pkg::ST_OUT;
         dcmf_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = last_res ? dcmf_pkg::ST_IDLE : dcmf_pkg::ST_SETUP;
            end
         end
         default:            state_in = dcmf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == dcmf_pkg::ST_IDLE) && !empty;
      rsp_valid = (state_ff == dcmf_pkg::ST_OUT);
      rsp_data.dark_value  = min_ff;
      rsp_data.out_col     = c_ff;
      rsp_data.out_row     = r_ff;
      rsp_data.last_of_run = last_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dcmf_pkg::ST_WRITE && job_ff.we) begin
         mem[waddr] <= job_ff.pix;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         dcmf_pkg::ST_IDLE: begin
            if (!empty) begin
               job_ff <= head;
            end
         end
         dcmf_pkg::ST_WRITE: begin
            r_ff <= job_ff.rlo;
            c_ff <= job_ff.clo;
         end
         dcmf_pkg::ST_SETUP: begin
            sr_ff   <= wlo;
            sc_ff   <= wclo;
            whi_ff  <= whi;
            wclo_ff <= wclo;
            wchi_ff <= wchi;
            min_ff  <= 8'hFF;
            pend_ff <= 1'b0;
         end
         dcmf_pkg::ST_SCAN: begin
            if (pend_ff && rdata_ff < min_ff) begin
               min_ff <= rdata_ff;
            end
            pend_ff <= 1'b1;
            if (sc_ff == wchi_ff) begin
               sc_ff <= wclo_ff;
               sr_ff <= sr_ff + 12'd1;
            end else begin
               sc_ff <= sc_ff + 12'd1;
            end
         end
         dcmf_pkg::ST_DRAIN: begin
            if (pend_ff && rdata_ff < min_ff) begin
               min_ff <= rdata_ff;
            end
            pend_ff <= 1'b0;
         end
         dcmf_pkg::ST_OUT: begin
            if (!rsp_stall && !last_res) begin
               if (c_ff == job_ff.chi) begin
                  c_ff <= job_ff.clo;
                  r_ff <= r_ff + 12'd1;
               end else begin
                  c_ff <= c_ff + 12'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/dark_channel_min_filter.sv =====
// Dark channel minimum filter top level.
//
// Usage: RGB pixels enter on req_* in raster order; one transaction each
// when req_valid is high and req_stall low. Results leave on rsp_* under the
// same valid/stall rule, each the minimum of the channel minima over a
// square window of side 2*radius+1 centred on (out_col, out_row), clipped at
// the image edges. last_of_run marks the final result caused by one pixel.
// Registers (width, height, radius) are written on csr_*, by the user only
// while idle (the block does not enforce this); csr_ready is always high.
// Throughput: the front takes a pixel per cycle into a two-entry queue while
// the queue is not full; the back takes one queued pixel at a time, writes it
// to the line store and then, per result, sets up the window, reads each
// window entry (up to 225 entries), drains the last read and presents the
// result, taking the next pixel only after its last result. Row and frame
// ends give up to 64 results for one pixel.
// Reset: position counters, queue and back-end FSM clear; the line store is not
// cleared. While rsp_stall is high the result holds and the back end waits;
// the front keeps accepting until the queue fills.
module dark_channel_min_filter #(
   parameter int MAX_RADIUS = dcmf_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dcmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcmf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_data
);

   logic [12:0] width_ff, height_ff;
   logic [2:0]  radius_ff;
   dcmf_pkg::cfg_type cfg;
   dcmf_pkg::job_type front_job, head;
   logic accept, full, empty, pop;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         radius_ff <= 3'd7;
      end else if (csr_valid) begin
         unique case (csr_index)
            dcmf_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            dcmf_pkg::CSR_HEIGHT: height_ff <= csr_data;
            dcmf_pkg::CSR_RADIUS: radius_ff <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.width  = (width_ff == 13'd0) ? 13'd1
                 : (width_ff > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_ff;
      cfg.height = (height_ff == 13'd0) ? 13'd1
                 : (height_ff > 13'(dcmf_pkg::MAX_HEIGHT)) ? 13'(dcmf_pkg::MAX_HEIGHT)
                 : height_ff;
      cfg.radius = (radius_ff > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_ff;
   end

   dcmf_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .pix_in (req_data),
      .accept (accept),
      .cfg    (cfg),
      .job    (front_job)
   );

   dcmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_job),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   dcmf_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/dcmf_checker.sv =====
// Port-level checks for the dark channel minimum filter, bound to the top.
module dcmf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dcmf_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result back to back");

   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind dark_channel_min_filter dcmf_checker u_dcmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
